// File: rtl/hpwm_pkg.sv
// Shared types, constants and the climate duty table for the heater PWM block.
`timescale 1ns / 1ps
`default_nettype none

package hpwm_pkg;

  localparam int BASE_TICKS  = 2000;
  localparam int MAX_FREQ    = 200;
  localparam int PCT_FULL    = 100;
  localparam int PCT_NUM     = 5;
  localparam int PCT_DEN     = 3;
  localparam int AUTO_FREQ   = 2;
  localparam int AUTO_PERIOD = BASE_TICKS / AUTO_FREQ;
  localparam int DUTY_SCALE  = AUTO_PERIOD / PCT_FULL;

  localparam int TICK_W = 11;
  localparam int FREQ_W = 8;
  localparam int PCT_W  = 7;
  localparam int PROD_W = 18;

  localparam logic [TICK_W-1:0] PERIOD_MAX   = '1;
  localparam logic [TICK_W-1:0] PERIOD_RESET = 11'd20;
  localparam logic [TICK_W-1:0] DUTY_RESET   = 11'd10;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 8'd100;
  localparam logic [PCT_W-1:0]  PCT_RESET  = 7'd50;

  // Configuration register indexes
  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_AUTO_MODE = 2'd1;
  localparam logic [1:0] REG_FREQ      = 2'd2;
  localparam logic [1:0] REG_DUTY_PCT  = 2'd3;

  // Command kinds passed from the front to the back
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_STOP = 2'd2;
  localparam logic [1:0] KIND_DIV  = 2'd3;

  // Climate bins
  localparam logic signed [7:0] TEMP_LIM0 = 8'sd10;
  localparam logic signed [7:0] TEMP_LIM1 = 8'sd28;
  localparam logic signed [7:0] TEMP_LIM2 = 8'sd35;
  localparam logic [6:0] HUM_LIM0 = 7'd55;
  localparam logic [6:0] HUM_LIM1 = 7'd65;
  localparam logic [6:0] HUM_LIM2 = 7'd75;
  localparam logic [6:0] HUM_LIM3 = 7'd85;

  localparam int TAB_ROWS = 5;
  localparam int TAB_COLS = 4;
  localparam int TAB_N    = TAB_ROWS * TAB_COLS;

  // Row-major: row is the humidity row, column the temperature bin
  localparam int DUTY_ENTRY [TAB_N] = '{
    42, 48, 54, 54,
    30, 42, 48, 54,
    18, 36, 42, 48,
    12, 24, 36, 48,
     0, 12, 30, 42
  };

  typedef logic [TAB_N-1:0][PCT_W-1:0] pct_tab_t;

  function automatic pct_tab_t make_pct_tab();
    pct_tab_t tab;
    for (int i = 0; i < TAB_N; i++) begin
      tab[i] = PCT_W'(DUTY_ENTRY[i] * PCT_NUM / PCT_DEN);
    end
    return tab;
  endfunction

  localparam pct_tab_t PCT_TABLE = make_pct_tab();

  typedef struct packed {
    logic              enable;
    logic              auto_mode;
    logic [FREQ_W-1:0] manual_freq;
    logic [PCT_W-1:0]  manual_duty_pct;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TICK_W-1:0] arg_a;
    logic [TICK_W-1:0] arg_b;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/hpwm_front.sv
// Front end: accepts input words and turns them into commands for the back end.
`timescale 1ns / 1ps
`default_nettype none

module hpwm_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic signed [7:0]  in_temperature,
  input  wire logic [6:0]         in_humidity,
  input  wire hpwm_pkg::cfg_t     cfg,
  input  wire logic               q_full,
  output logic                    q_push,
  output hpwm_pkg::cmd_t          q_cmd
);

  logic [1:0]                     temp_bin;
  logic [2:0]                     hum_gt;
  logic [2:0]                     hum_row;
  logic [4:0]                     tab_idx;
  logic [hpwm_pkg::PCT_W-1:0]     auto_pct;
  logic [hpwm_pkg::FREQ_W-1:0]    freq_c;
  logic [hpwm_pkg::PCT_W-1:0]     pct_c;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    temp_bin = 2'(in_temperature > hpwm_pkg::TEMP_LIM0)
             + 2'(in_temperature > hpwm_pkg::TEMP_LIM1)
             + 2'(in_temperature > hpwm_pkg::TEMP_LIM2);
    hum_gt   = 3'(in_humidity > hpwm_pkg::HUM_LIM0)
             + 3'(in_humidity > hpwm_pkg::HUM_LIM1)
             + 3'(in_humidity > hpwm_pkg::HUM_LIM2)
             + 3'(in_humidity > hpwm_pkg::HUM_LIM3);
    hum_row  = 3'(hpwm_pkg::TAB_ROWS - 1) - hum_gt;
    tab_idx  = {hum_row, temp_bin};
    auto_pct = hpwm_pkg::PCT_TABLE[tab_idx];

    freq_c = (cfg.manual_freq > hpwm_pkg::FREQ_W'(hpwm_pkg::MAX_FREQ))
           ? hpwm_pkg::FREQ_W'(hpwm_pkg::MAX_FREQ) : cfg.manual_freq;
    pct_c  = (cfg.manual_duty_pct > hpwm_pkg::PCT_W'(hpwm_pkg::PCT_FULL))
           ? hpwm_pkg::PCT_W'(hpwm_pkg::PCT_FULL) : cfg.manual_duty_pct;

    q_cmd.kind  = hpwm_pkg::KIND_TICK;
    q_cmd.arg_a = '0;
    q_cmd.arg_b = '0;
    if (in_func) begin
      if (cfg.auto_mode) begin
        // Auto period is fixed, so duty is a scaled table percent
        q_cmd.kind  = hpwm_pkg::KIND_LOAD;
        q_cmd.arg_a = hpwm_pkg::TICK_W'(hpwm_pkg::AUTO_PERIOD);
        q_cmd.arg_b = hpwm_pkg::TICK_W'(auto_pct)
                    * hpwm_pkg::TICK_W'(hpwm_pkg::DUTY_SCALE);
      end else if (cfg.manual_freq == '0) begin
        q_cmd.kind = hpwm_pkg::KIND_STOP;
      end else begin
        q_cmd.kind  = hpwm_pkg::KIND_DIV;
        q_cmd.arg_a = hpwm_pkg::TICK_W'(freq_c);
        q_cmd.arg_b = hpwm_pkg::TICK_W'(pct_c);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/hpwm_fifo.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module hpwm_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire hpwm_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output hpwm_pkg::cmd_t      pop_cmd,
  output logic                full,
  output logic                empty
);

  hpwm_pkg::cmd_t slot_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hpwm_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module hpwm_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [hpwm_pkg::PROD_W-1:0] dividend,
  input  wire logic [hpwm_pkg::FREQ_W-1:0] divisor,
  output logic                             done,
  output logic [hpwm_pkg::PROD_W-1:0]      quot
);

  localparam int CNT_W = $clog2(hpwm_pkg::PROD_W);

  logic [hpwm_pkg::FREQ_W-1:0] rem_r, rem_nxt;
  logic [hpwm_pkg::PROD_W-1:0] quo_r, quo_nxt;
  logic [hpwm_pkg::FREQ_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [hpwm_pkg::FREQ_W:0]   rem_sh;
  logic [hpwm_pkg::FREQ_W+1:0] diff;

  assign done = done_r;
  assign quot = quo_r;

  always_comb begin
    rem_sh   = {rem_r, quo_r[hpwm_pkg::PROD_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dsr_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Subtract when it does not borrow; shift the quotient bit in
      if (diff[hpwm_pkg::FREQ_W+1]) begin
        rem_nxt = rem_sh[hpwm_pkg::FREQ_W-1:0];
      end else begin
        rem_nxt = diff[hpwm_pkg::FREQ_W-1:0];
      end
      quo_nxt = {quo_r[hpwm_pkg::PROD_W-2:0], !diff[hpwm_pkg::FREQ_W+1]};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(hpwm_pkg::PROD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/hpwm_back.sv
// Back end: runs commands against the PWM state and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module hpwm_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire hpwm_pkg::cfg_t              cfg,
  input  wire logic                        q_empty,
  input  wire hpwm_pkg::cmd_t              q_cmd,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_heater_on,
  output logic [hpwm_pkg::TICK_W-1:0]      out_period_ticks,
  output logic [hpwm_pkg::TICK_W-1:0]      out_duty_ticks
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_DIV_PER = 2'd1;
  localparam logic [1:0] ST_MUL     = 2'd2;
  localparam logic [1:0] ST_SCALE   = 2'd3;

  localparam logic [hpwm_pkg::PROD_W-1:0] BASE_DIVIDEND =
    hpwm_pkg::PROD_W'(hpwm_pkg::BASE_TICKS);

  localparam int PERIOD_MAX_W = (1 << hpwm_pkg::TICK_W) - 1;

  // Divide by 100 as a multiply by ceil(2^25/100) and a shift by 25;
  // exact for every dividend below 2^18
  localparam int                 RECIP_W     = 19;
  localparam int                 RECIP_SHIFT = 25;
  localparam int                 RPROD_W     = hpwm_pkg::PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_MUL   = 19'd335545;

  logic [1:0]                  state_r, state_nxt;
  logic [hpwm_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [hpwm_pkg::TICK_W-1:0] period_r, period_nxt;
  logic [hpwm_pkg::TICK_W-1:0] duty_r, duty_nxt;
  logic                        pin_r, pin_nxt;
  logic                        stopped_r, stopped_nxt;
  logic [hpwm_pkg::TICK_W-1:0] per_r, per_nxt;
  logic [hpwm_pkg::PCT_W-1:0]  pct_r, pct_nxt;
  logic [hpwm_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic                        ovalid_r, ovalid_nxt;
  logic                        opin_r, opin_nxt;
  logic [hpwm_pkg::TICK_W-1:0] oper_r, oper_nxt;
  logic [hpwm_pkg::TICK_W-1:0] oduty_r, oduty_nxt;

  logic [hpwm_pkg::TICK_W-1:0] tick_inc;
  logic                        out_free;
  logic                        div_start;
  logic [hpwm_pkg::PROD_W-1:0] div_dividend;
  logic [hpwm_pkg::FREQ_W-1:0] div_divisor;
  logic                        div_done;
  logic [hpwm_pkg::PROD_W-1:0] div_quot;
  logic [RPROD_W-1:0]          recip_prod;
  logic                        emit;

  hpwm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign out_valid        = ovalid_r;
  assign out_heater_on    = opin_r;
  assign out_period_ticks = oper_r;
  assign out_duty_ticks   = oduty_r;

  assign out_free     = !ovalid_r || out_ready;
  assign q_pop        = (state_r == ST_IDLE) && !q_empty && out_free;
  assign tick_inc     = tick_r + hpwm_pkg::TICK_W'(1);
  assign div_dividend = BASE_DIVIDEND;
  assign div_divisor  = q_cmd.arg_a[hpwm_pkg::FREQ_W-1:0];
  assign recip_prod   = RPROD_W'(prod_r) * RPROD_W'(RECIP_MUL);

  always_comb begin
    state_nxt    = state_r;
    tick_nxt     = tick_r;
    period_nxt   = period_r;
    duty_nxt     = duty_r;
    pin_nxt      = pin_r;
    stopped_nxt  = stopped_r;
    per_nxt      = per_r;
    pct_nxt      = pct_r;
    prod_nxt     = prod_r;
    div_start    = 1'b0;
    emit         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          case (q_cmd.kind)
            hpwm_pkg::KIND_TICK: begin
              emit = 1'b1;
              if (cfg.enable && !stopped_r) begin
                if (tick_inc >= period_r) begin
                  tick_nxt = '0;
                  if (duty_r != '0) begin
                    pin_nxt = 1'b1;
                  end
                end else begin
                  tick_nxt = tick_inc;
                  if (tick_inc >= duty_r) begin
                    pin_nxt = 1'b0;
                  end
                end
              end
            end
            hpwm_pkg::KIND_LOAD: begin
              emit        = 1'b1;
              period_nxt  = q_cmd.arg_a;
              duty_nxt    = q_cmd.arg_b;
              stopped_nxt = 1'b0;
            end
            hpwm_pkg::KIND_STOP: begin
              emit        = 1'b1;
              stopped_nxt = 1'b1;
              pin_nxt     = 1'b0;
            end
            default: begin
              // Manual reload: period from the base count, then duty
              div_start = 1'b1;
              pct_nxt   = q_cmd.arg_b[hpwm_pkg::PCT_W-1:0];
              state_nxt = ST_DIV_PER;
            end
          endcase
        end
      end
      ST_DIV_PER: begin
        if (div_done) begin
          if (div_quot > hpwm_pkg::PROD_W'(PERIOD_MAX_W)) begin
            per_nxt = hpwm_pkg::PERIOD_MAX;
          end else begin
            per_nxt = div_quot[hpwm_pkg::TICK_W-1:0];
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = hpwm_pkg::PROD_W'(per_r) * hpwm_pkg::PROD_W'(pct_r);
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        emit        = 1'b1;
        period_nxt  = per_r;
        duty_nxt    = recip_prod[RECIP_SHIFT +: hpwm_pkg::TICK_W];
        stopped_nxt = 1'b0;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    ovalid_nxt = ovalid_r && !out_ready;
    opin_nxt   = opin_r;
    oper_nxt   = oper_r;
    oduty_nxt  = oduty_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      opin_nxt   = pin_nxt;
      oper_nxt   = period_nxt;
      oduty_nxt  = duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      tick_r    <= '0;
      period_r  <= hpwm_pkg::PERIOD_RESET;
      duty_r    <= hpwm_pkg::DUTY_RESET;
      pin_r     <= 1'b0;
      stopped_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tick_r    <= tick_nxt;
      period_r  <= period_nxt;
      duty_r    <= duty_nxt;
      pin_r     <= pin_nxt;
      stopped_r <= stopped_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    per_r   <= per_nxt;
    pct_r   <= pct_nxt;
    prod_r  <= prod_nxt;
    opin_r  <= opin_nxt;
    oper_r  <= oper_nxt;
    oduty_r <= oduty_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/heater_pwm_with_climate_duty_table_top.sv
// Top level of the heater PWM driver: configuration registers and block wiring.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_ready   func, temperature, humidity
//   out_      output     out_valid / out_ready heater_on, period_ticks, duty_ticks
//   cfg_      input      cfg_we                cfg_index, cfg_wdata
//
// Ticks, auto reloads and stop reloads are handled in the back end's idle state, so a
// stream of them runs at one word per cycle while out_ready stays high. A manual
// reload holds the back end while it starts the one-bit-per-cycle period divider,
// takes its quotient, forms period times percent and scales that by 1/100.
// Reset is synchronous, active low, and needs no clearing pass.
// A two-entry command queue takes words while the back end is busy or the output is
// stalled; in_ready drops once both entries are full.
`timescale 1ns / 1ps
`default_nettype none

module heater_pwm_with_climate_duty_table_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [hpwm_pkg::FREQ_W-1:0]   cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  input  wire logic signed [7:0]             in_temperature,
  input  wire logic [6:0]                    in_humidity,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_heater_on,
  output logic [hpwm_pkg::TICK_W-1:0]        out_period_ticks,
  output logic [hpwm_pkg::TICK_W-1:0]        out_duty_ticks
);

  hpwm_pkg::cfg_t cfg_r, cfg_nxt;
  hpwm_pkg::cmd_t push_cmd;
  hpwm_pkg::cmd_t pop_cmd;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        hpwm_pkg::REG_ENABLE:    cfg_nxt.enable          = cfg_wdata[0];
        hpwm_pkg::REG_AUTO_MODE: cfg_nxt.auto_mode       = cfg_wdata[0];
        hpwm_pkg::REG_FREQ:      cfg_nxt.manual_freq     = cfg_wdata;
        hpwm_pkg::REG_DUTY_PCT:  cfg_nxt.manual_duty_pct = cfg_wdata[hpwm_pkg::PCT_W-1:0];
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable          <= 1'b1;
      cfg_r.auto_mode       <= 1'b1;
      cfg_r.manual_freq     <= hpwm_pkg::FREQ_RESET;
      cfg_r.manual_duty_pct <= hpwm_pkg::PCT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hpwm_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_temperature (in_temperature),
    .in_humidity    (in_humidity),
    .cfg            (cfg_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  hpwm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  hpwm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_cmd            (pop_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_heater_on    (out_heater_on),
    .out_period_ticks (out_period_ticks),
    .out_duty_ticks   (out_duty_ticks)
  );

endmodule

`default_nettype wire

// File: tb/tb_heater_pwm_with_climate_duty_table_top.sv
// Self-checking testbench for the heater PWM driver with its climate duty table.
`timescale 1ns / 1ps

module tb_heater_pwm_with_climate_duty_table_top;

  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_RELOAD = 1'b1;

  localparam int HEAT_BASE  = 2000;
  localparam int FREQ_CAP   = 200;
  localparam int PCT_CAP    = 100;
  localparam int AUTO_DIV   = 2;
  localparam int PERIOD_TOP = 2047;
  localparam int MAX_PRINTS = 50;

  // Rows by humidity (row 0 the wettest), columns by temperature bin
  localparam int CLIMATE_DUTY [5][4] = '{
    '{42, 48, 54, 54},
    '{30, 42, 48, 54},
    '{18, 36, 42, 48},
    '{12, 24, 36, 48},
    '{ 0, 12, 30, 42}
  };
  localparam int TEMP_BOUND [3] = '{10, 28, 35};
  localparam int HUM_BOUND  [4] = '{55, 65, 75, 85};

  localparam int TEMP_EDGES [14] = '{-128, -41, -40, 9, 10, 11, 27, 28, 29, 34, 35, 36,
                                     126, 127};
  localparam int HUM_EDGES  [16] = '{0, 54, 55, 56, 64, 65, 66, 74, 75, 76, 84, 85, 86,
                                     100, 101, 127};

  typedef struct packed {
    logic                        heater_on;
    logic [hpwm_pkg::TICK_W-1:0] period_ticks;
    logic [hpwm_pkg::TICK_W-1:0] duty_ticks;
  } pwm_word_t;

  class pwm_scoreboard;
    logic                        en;
    logic                        auto_on;
    logic [hpwm_pkg::FREQ_W-1:0] freq;
    logic [hpwm_pkg::PCT_W-1:0]  pct;
    logic [hpwm_pkg::TICK_W-1:0] count;
    logic [hpwm_pkg::TICK_W-1:0] period;
    logic [hpwm_pkg::TICK_W-1:0] duty;
    logic                        pin;
    logic                        halted;
    pwm_word_t                   expected_words [$];
    int                          errors;

    function new();
      en      = 1'b1;
      auto_on = 1'b1;
      freq    = 8'd100;
      pct     = 7'd50;
      count   = '0;
      period  = 11'd20;
      duty    = 11'd10;
      pin     = 1'b0;
      halted  = 1'b0;
      errors  = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    function int pending();
      return expected_words.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [hpwm_pkg::FREQ_W-1:0] val);
      case (idx)
        hpwm_pkg::REG_ENABLE:    en = val[0];
        hpwm_pkg::REG_AUTO_MODE: auto_on = val[0];
        hpwm_pkg::REG_FREQ:      freq = val;
        hpwm_pkg::REG_DUTY_PCT:  pct = val[hpwm_pkg::PCT_W-1:0];
        default: ;
      endcase
    endfunction

    function void load_period(int unsigned f, int unsigned p);
      int unsigned per;
      if (f > FREQ_CAP) f = FREQ_CAP;
      if (f == 0) f = 1;
      if (p > PCT_CAP) p = PCT_CAP;
      per = HEAT_BASE / f;
      if (per > PERIOD_TOP) per = PERIOD_TOP;
      period = per[hpwm_pkg::TICK_W-1:0];
      duty   = hpwm_pkg::TICK_W'(per * p / PCT_CAP);
      halted = 1'b0;
    endfunction

    // Advance the PWM state for one accepted word and queue the word it must produce
    function void note_word(logic func, logic signed [7:0] temp, logic [6:0] hum);
      int        t;
      int        tbin;
      int        k;
      pwm_word_t w;
      if (func == FUNC_TICK) begin
        if (en && !halted) begin
          count = count + 11'd1;
          if (count >= period) begin
            if (duty != 0) pin = 1'b1;
            count = '0;
          end else if (count >= duty) begin
            pin = 1'b0;
          end
        end
      end else if (auto_on) begin
        t = temp;
        tbin = 0;
        while (tbin < 3 && t > TEMP_BOUND[tbin]) tbin++;
        k = 0;
        while (k < 4 && int'(hum) > HUM_BOUND[k]) k++;
        load_period(AUTO_DIV, CLIMATE_DUTY[4 - k][tbin] * 5 / 3);
      end else if (freq == 0) begin
        halted = 1'b1;
        pin    = 1'b0;
      end else begin
        load_period(freq, pct);
      end
      w.heater_on    = pin;
      w.period_ticks = period;
      w.duty_ticks   = duty;
      expected_words.push_back(w);
    endfunction

    task check_word(logic on, logic [hpwm_pkg::TICK_W-1:0] per,
                    logic [hpwm_pkg::TICK_W-1:0] dty);
      pwm_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word on=%0b period=%0d duty=%0d", on, per, dty));
        return;
      end
      w = expected_words.pop_front();
      if (on !== w.heater_on)
        report($sformatf("heater_on got %0b want %0b", on, w.heater_on));
      if (per !== w.period_ticks)
        report($sformatf("period_ticks got %0d want %0d", per, w.period_ticks));
      if (dty !== w.duty_ticks)
        report($sformatf("duty_ticks got %0d want %0d", dty, w.duty_ticks));
    endtask
  endclass

  logic                        clk            = 1'b0;
  logic                        rst_n          = 1'b0;
  logic                        cfg_we         = 1'b0;
  logic [1:0]                  cfg_index      = hpwm_pkg::REG_ENABLE;
  logic [hpwm_pkg::FREQ_W-1:0] cfg_wdata      = '0;
  logic                        in_valid       = 1'b0;
  logic                        in_ready;
  logic                        in_func        = FUNC_TICK;
  logic signed [7:0]           in_temperature = '0;
  logic [6:0]                  in_humidity    = '0;
  logic                        out_valid;
  logic                        out_ready      = 1'b0;
  logic                        out_heater_on;
  logic [hpwm_pkg::TICK_W-1:0] out_period_ticks;
  logic [hpwm_pkg::TICK_W-1:0] out_duty_ticks;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  pwm_scoreboard sb = new();

  heater_pwm_with_climate_duty_table_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_temperature   (in_temperature),
    .in_humidity      (in_humidity),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_heater_on    (out_heater_on),
    .out_period_ticks (out_period_ticks),
    .out_duty_ticks   (out_duty_ticks)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_word(in_func, in_temperature, in_humidity);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_heater_on, out_period_ticks, out_duty_ticks);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_word(input logic f, input logic signed [7:0] t, input logic [6:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_temperature <= t;
    in_humidity    <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the sender until every queued word has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic set_regs(input logic en, input logic am,
                          input logic [hpwm_pkg::FREQ_W-1:0] f,
                          input logic [hpwm_pkg::PCT_W-1:0] p);
    logic [1:0]                  idxs [4];
    logic [hpwm_pkg::FREQ_W-1:0] vals [4];
    idxs = '{hpwm_pkg::REG_ENABLE, hpwm_pkg::REG_AUTO_MODE, hpwm_pkg::REG_FREQ,
             hpwm_pkg::REG_DUTY_PCT};
    vals = '{{7'd0, en}, {7'd0, am}, f, {1'b0, p}};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(input int reload_pct, input bit force_reload);
    logic              f;
    logic signed [7:0] t;
    logic [6:0]        h;
    f = (force_reload || $urandom_range(99) < reload_pct) ? FUNC_RELOAD : FUNC_TICK;
    if ($urandom_range(3) == 0) t = 8'(TEMP_EDGES[$urandom_range(13)]);
    else t = 8'($urandom_range(255));
    if ($urandom_range(3) == 0) h = 7'(HUM_EDGES[$urandom_range(15)]);
    else h = 7'($urandom_range(127));
    send_word(f, t, h);
  endtask

  task automatic run_directed();
    // Climate bins at their edges and the table corners, reset settings
    send_word(FUNC_TICK, 8'sd0, 7'd0);
    send_word(FUNC_TICK, -8'sd1, 7'd127);
    send_word(FUNC_RELOAD, -8'sd128, 7'd127);
    send_word(FUNC_RELOAD, 8'sd127, 7'd0);
    send_word(FUNC_RELOAD, 8'sd10, 7'd55);
    send_word(FUNC_RELOAD, 8'sd11, 7'd56);
    send_word(FUNC_RELOAD, 8'sd35, 7'd85);
    send_word(FUNC_RELOAD, 8'sd36, 7'd86);
    wait_drain();
    // Frequency and percent both over their caps: duty equals period
    set_regs(1'b1, 1'b0, 8'd255, 7'd127);
    send_word(FUNC_RELOAD, 8'sd0, 7'd0);
    repeat (9) send_word(FUNC_TICK, 8'sd0, 7'd0);
    wait_drain();
    // Frequency zero stops the heater and freezes ticks
    set_regs(1'b1, 1'b0, 8'd0, 7'd50);
    send_word(FUNC_RELOAD, 8'sd0, 7'd0);
    send_word(FUNC_TICK, 8'sd0, 7'd0);
    wait_drain();
    set_regs(1'b0, 1'b0, 8'd200, 7'd0);
    send_word(FUNC_RELOAD, 8'sd0, 7'd0);
    send_word(FUNC_TICK, 8'sd0, 7'd0);
    wait_drain();
    set_regs(1'b1, 1'b0, 8'd1, 7'd100);
    send_word(FUNC_RELOAD, 8'sd0, 7'd0);
    send_word(FUNC_TICK, 8'sd0, 7'd0);
    wait_drain();
  endtask

  initial begin
    logic                        en;
    logic                        am;
    logic [hpwm_pkg::FREQ_W-1:0] f;
    logic [hpwm_pkg::PCT_W-1:0]  p;
    int                          n;
    int                          reload_pct;
    int                          drain_at;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();

    for (int ph = 0; ph < 11; ph++) begin
      n = 17;
      reload_pct = 12;
      case (ph)
        0: begin en = 1'b1; am = 1'b0; f = 8'd255; p = 7'd127; end
        1: begin en = 1'b1; am = 1'b0; f = 8'd200; p = 7'd0; end
        2: begin en = 1'b1; am = 1'b1; f = 8'd100; p = 7'd50; end
        3: begin en = 1'b0; am = 1'b0; f = 8'd150; p = 7'd30; end
        4: begin en = 1'b1; am = 1'b0; f = 8'd0; p = 7'd60; end
        5: begin
          // Long auto run so the counter wraps a 1000-tick period
          en = 1'b1; am = 1'b1; f = 8'd1; p = 7'd100;
          n = 1060;
          reload_pct = 1;
        end
        default: begin
          en = ($urandom_range(9) != 0);
          am = ($urandom_range(3) == 0);
          f  = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255, 99));
          p  = 7'($urandom_range(127));
        end
      endcase
      set_regs(en, am, f, p);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      drain_at = $urandom_range(n - 1, 1);
      for (int k = 0; k < n; k++) begin
        if (k == drain_at) wait_drain();
        send_random(reload_pct, k == 0);
      end
      wait_drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (64) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d words never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("tb_heater_pwm_with_climate_duty_table_top: PASS");
    end else begin
      $display("tb_heater_pwm_with_climate_duty_table_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d words outstanding", sb.pending());
    $display("tb_heater_pwm_with_climate_duty_table_top: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/hpwm_pkg.sv
rtl/hpwm_front.sv
rtl/hpwm_fifo.sv
rtl/hpwm_div.sv
rtl/hpwm_back.sv
rtl/heater_pwm_with_climate_duty_table_top.sv
tb/tb_heater_pwm_with_climate_duty_table_top.sv
